// ===== rtl/adv_data_service_uuid_filter_core_defines.svh =====
// assertion macros for the uuid filter core
`ifndef ADV_DATA_SERVICE_UUID_FILTER_CORE_DEFINES_SVH
`define ADV_DATA_SERVICE_UUID_FILTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define ADSUF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("adsuf assertion failed");

// antecedent implies consequent in the next cycle
`define ADSUF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("adsuf assertion failed");

`else

`define ADSUF_ASSERT_NOW(label, ante, cons)
`define ADSUF_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/adsuf_pkg.sv =====
package adsuf_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned UUID_BYTES = 16;
  localparam int unsigned POS_W      = $clog2(UUID_BYTES);
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 1;

  // advertising structure types carrying 128-bit service uuid lists
  localparam logic [BYTE_W-1:0] AD_TYPE_UUID128_PART = 8'h06;
  localparam logic [BYTE_W-1:0] AD_TYPE_UUID128_FULL = 8'h07;

  // shortest accepted length: a type byte and at least one data byte
  localparam logic [BYTE_W-1:0] MIN_FIELD_LEN = 8'd2;

  localparam logic [POS_W-1:0] CHUNK_LAST_POS = POS_W'(UUID_BYTES - 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UUID_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_UUID_HIGH = 1'b1;

  typedef enum logic [2:0] {
    PHASE_LENGTH = 3'b001,
    PHASE_TYPE   = 3'b010,
    PHASE_VALUE  = 3'b100
  } phase_t;

endpackage

// ===== rtl/adv_data_service_uuid_filter_core.sv =====
// a request with last_byte set shows its result in the cycle after acceptance
// throughput: one byte per cycle while byte_ready is high; the parser state update is a single registered pass
// a result left waiting holds off new bytes; the next byte enters in the cycle it is taken
// reset: synchronous active-high rst clears the parser, the uuid registers and result_valid
`include "adv_data_service_uuid_filter_core_defines.svh"

module adv_data_service_uuid_filter_core (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration write port
  input  logic                                   cfg_we,
  input  logic [adsuf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [adsuf_pkg::CFG_DATA_W-1:0]       cfg_data,
  // report byte requests
  input  logic                                   byte_valid,
  output logic                                   byte_ready,
  input  logic [adsuf_pkg::BYTE_W-1:0]           data_byte,
  input  logic                                   last_byte,
  // per-report result
  output logic                                   result_valid,
  input  logic                                   result_ready,
  output logic                                   service_found
);

  // configured uuid, byte 0 in uuid_low[7:0]
  logic [adsuf_pkg::CFG_DATA_W-1:0] uuid_low;
  logic [adsuf_pkg::CFG_DATA_W-1:0] uuid_high;

  // parser state
  adsuf_pkg::phase_t                 parse_phase, parse_phase_next;
  logic [adsuf_pkg::BYTE_W-1:0]      field_bytes_left, field_bytes_left_next;
  logic                              uuid_list_field, uuid_list_field_next;
  logic [adsuf_pkg::POS_W-1:0]       chunk_position, chunk_position_next;
  logic                              chunk_all_equal, chunk_all_equal_next;
  logic                              field_match_pending, field_match_pending_next;
  logic                              match_committed, match_committed_next;
  logic                              parse_stopped, parse_stopped_next;

  logic                              byte_accept;
  logic [adsuf_pkg::BYTE_W-1:0]      uuid_byte;
  logic [adsuf_pkg::BYTE_W-1:0]      bytes_left_dec;
  logic                              chunk_equal_now;

  // a byte can enter whenever the result slot is free or being emptied now
  assign byte_ready  = !result_valid || result_ready;
  assign byte_accept = byte_valid && byte_ready;

  // uuid byte for the current chunk position, bit 3 picks the upper word
  always_comb begin
    if (chunk_position[adsuf_pkg::POS_W-1]) begin
      uuid_byte = uuid_high[{chunk_position[adsuf_pkg::POS_W-2:0], 3'b000} +: adsuf_pkg::BYTE_W];
    end else begin
      uuid_byte = uuid_low[{chunk_position[adsuf_pkg::POS_W-2:0], 3'b000} +: adsuf_pkg::BYTE_W];
    end
  end

  assign bytes_left_dec  = field_bytes_left - adsuf_pkg::BYTE_W'(1);
  assign chunk_equal_now = chunk_all_equal && (data_byte == uuid_byte);

  // one parse step per accepted byte
  always_comb begin
    parse_phase_next         = parse_phase;
    field_bytes_left_next    = field_bytes_left;
    uuid_list_field_next     = uuid_list_field;
    chunk_position_next      = chunk_position;
    chunk_all_equal_next     = chunk_all_equal;
    field_match_pending_next = field_match_pending;
    match_committed_next     = match_committed;
    parse_stopped_next       = parse_stopped;

    if (byte_accept && !parse_stopped) begin
      case (parse_phase)
        adsuf_pkg::PHASE_TYPE: begin
          uuid_list_field_next     = (data_byte == adsuf_pkg::AD_TYPE_UUID128_PART) ||
                                     (data_byte == adsuf_pkg::AD_TYPE_UUID128_FULL);
          field_bytes_left_next    = bytes_left_dec;
          chunk_position_next      = '0;
          chunk_all_equal_next     = 1'b1;
          field_match_pending_next = 1'b0;
          parse_phase_next         = adsuf_pkg::PHASE_VALUE;
        end
        adsuf_pkg::PHASE_VALUE: begin
          if (uuid_list_field) begin
            if (chunk_position == adsuf_pkg::CHUNK_LAST_POS) begin
              // whole chunk seen, remember a match until the field closes
              if (chunk_equal_now) begin
                field_match_pending_next = 1'b1;
              end
              chunk_position_next  = '0;
              chunk_all_equal_next = 1'b1;
            end else begin
              chunk_position_next  = chunk_position + adsuf_pkg::POS_W'(1);
              chunk_all_equal_next = chunk_equal_now;
            end
          end
          field_bytes_left_next = bytes_left_dec;
          if (bytes_left_dec == '0) begin
            // field ends inside the report, a pending match now counts
            if (field_match_pending_next) begin
              match_committed_next = 1'b1;
            end
            field_match_pending_next = 1'b0;
            parse_phase_next         = adsuf_pkg::PHASE_LENGTH;
          end
        end
        default: begin
          // length byte; unused phase codes land here too
          if (data_byte < adsuf_pkg::MIN_FIELD_LEN) begin
            parse_stopped_next = 1'b1;
          end else begin
            field_bytes_left_next = data_byte;
            parse_phase_next      = adsuf_pkg::PHASE_TYPE;
          end
        end
      endcase
    end

    // end of report: parser starts over for the next one
    if (byte_accept && last_byte) begin
      parse_phase_next         = adsuf_pkg::PHASE_LENGTH;
      field_bytes_left_next    = '0;
      uuid_list_field_next     = 1'b0;
      chunk_position_next      = '0;
      chunk_all_equal_next     = 1'b1;
      field_match_pending_next = 1'b0;
      match_committed_next     = 1'b0;
      parse_stopped_next       = 1'b0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      uuid_low  <= '0;
      uuid_high <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        adsuf_pkg::CFG_UUID_LOW:  uuid_low  <= cfg_data;
        adsuf_pkg::CFG_UUID_HIGH: uuid_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase         <= adsuf_pkg::PHASE_LENGTH;
      field_bytes_left    <= '0;
      uuid_list_field     <= 1'b0;
      chunk_position      <= '0;
      chunk_all_equal     <= 1'b1;
      field_match_pending <= 1'b0;
      match_committed     <= 1'b0;
      parse_stopped       <= 1'b0;
    end else begin
      parse_phase         <= parse_phase_next;
      field_bytes_left    <= field_bytes_left_next;
      uuid_list_field     <= uuid_list_field_next;
      chunk_position      <= chunk_position_next;
      chunk_all_equal     <= chunk_all_equal_next;
      field_match_pending <= field_match_pending_next;
      match_committed     <= match_committed_next;
      parse_stopped       <= parse_stopped_next;
    end
  end

  // result register, loaded on the last byte of a report
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (byte_accept && last_byte) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // payload carries no reset; take the committed flag after this byte's step
  always_ff @(posedge clk) begin
    if (byte_accept && last_byte) begin
      // a field closing on the last byte still counts
      if (!parse_stopped && (parse_phase == adsuf_pkg::PHASE_VALUE) &&
          (bytes_left_dec == '0) &&
          (field_match_pending ||
           (uuid_list_field && (chunk_position == adsuf_pkg::CHUNK_LAST_POS) &&
            chunk_equal_now))) begin
        service_found <= 1'b1;
      end else begin
        service_found <= match_committed;
      end
    end
  end

  // checks
  `ADSUF_ASSERT_NEXT(a_last_gives_result, byte_accept && last_byte, result_valid)
  `ADSUF_ASSERT_NEXT(a_taken_result_clears,
    result_valid && result_ready && !(byte_accept && last_byte), !result_valid)
  `ADSUF_ASSERT_NEXT(a_report_restarts, byte_accept && last_byte,
    (parse_phase == adsuf_pkg::PHASE_LENGTH) && !parse_stopped && !match_committed)
  `ADSUF_ASSERT_NOW(a_pending_in_uuid_field, field_match_pending, uuid_list_field)

endmodule
